// File: rtl/sdps_pkg.sv
// ----------------------------------------------------------------------------
// sdps_pkg
// Shared types, constants and glyph table for the segment display pulse
// sequencer.
// ----------------------------------------------------------------------------
package sdps_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_SEGS_PER_GROUP = 2'd0;
  localparam logic [1:0] CFG_CLEAR_MS       = 2'd1;
  localparam logic [1:0] CFG_SET_MS         = 2'd2;

  // Register reset values
  localparam logic [2:0]  SEGS_PER_GROUP_RST = 3'd2;
  localparam logic [15:0] CLEAR_MS_RST       = 16'd75;
  localparam logic [15:0] SET_MS_RST         = 16'd250;

  // Fixed display values
  localparam logic [7:0] COM_BIT      = 8'h80;
  localparam logic [6:0] ALL_SEGS     = 7'h7F;
  localparam logic [6:0] GLYPH_SMALL_O = 7'h5C;
  localparam logic [6:0] GLYPH_BIG_F   = 7'h71;
  localparam logic [7:0] MAX_SHOWN    = 8'd99;
  localparam int unsigned NUM_SEGS    = 7;

  // Sequencer phases
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR_TENS,
    ST_SET_TENS,
    ST_CLR_ONES,
    ST_SET_ONES
  } seq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture a new count value
    logic run;    // work one segment group this cycle
    logic digit;  // 0 tens, 1 ones
    logic pol;    // 0 clear, 1 set
  } sdps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic group_last;  // current group is the last of the digit
    logic tens_blank;  // tens digit is blanked
  } sdps_status_t;

  // Decimal digit to segment pattern gfedcba
  function automatic logic [6:0] digit_glyph(input logic [3:0] d);
    logic [6:0] g;
    case (d)
      4'd0:    g = 7'b0111111;
      4'd1:    g = 7'b0000110;
      4'd2:    g = 7'b1011011;
      4'd3:    g = 7'b1001111;
      4'd4:    g = 7'b1100110;
      4'd5:    g = 7'b1101101;
      4'd6:    g = 7'b1111101;
      4'd7:    g = 7'b0000111;
      4'd8:    g = 7'b1111111;
      4'd9:    g = 7'b1101111;
      default: g = 7'b0000000;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/sdps_ctrl.sv
// ----------------------------------------------------------------------------
// sdps_ctrl
// Phase controller: walks clear tens, set tens (skipped when the tens digit
// is blank), clear ones, set ones, one segment group per cycle.
// ----------------------------------------------------------------------------
module sdps_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  sdps_pkg::sdps_status_t status,
  output sdps_pkg::sdps_cmd_t   cmd,
  output logic                  busy
);
  import sdps_pkg::*;

  seq_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CLR_TENS;
        end
      end
      ST_CLR_TENS: begin
        cmd.run = 1'b1;
        if (status.group_last) begin
          state_next = status.tens_blank ? ST_CLR_ONES : ST_SET_TENS;
        end
      end
      ST_SET_TENS: begin
        cmd.run = 1'b1;
        cmd.pol = 1'b1;
        if (status.group_last) begin
          state_next = ST_CLR_ONES;
        end
      end
      ST_CLR_ONES: begin
        cmd.run   = 1'b1;
        cmd.digit = 1'b1;
        if (status.group_last) begin
          state_next = ST_SET_ONES;
        end
      end
      ST_SET_ONES: begin
        cmd.run   = 1'b1;
        cmd.digit = 1'b1;
        cmd.pol   = 1'b1;
        if (status.group_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: rtl/sdps_dp.sv
// ----------------------------------------------------------------------------
// sdps_dp
// Datapath: digit split and glyph lookup, group offset counter, pulse byte
// formation and the registered result.
// ----------------------------------------------------------------------------
module sdps_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  sdps_pkg::sdps_cmd_t   cmd,
  input  logic [7:0]            count_value,
  input  logic [2:0]            segments_per_group,
  input  logic [15:0]           clear_pulse_ms,
  input  logic [15:0]           set_pulse_ms,
  output sdps_pkg::sdps_status_t status,
  output logic                  pulse_valid,
  output logic                  digit_select,
  output logic                  polarity,
  output logic [6:0]            segment_mask,
  output logic [7:0]            dir_port0,
  output logic [7:0]            level_port0,
  output logic [7:0]            dir_port1,
  output logic [7:0]            level_port1,
  output logic [15:0]           pulse_ms,
  output logic                  last_pulse
);
  import sdps_pkg::*;

  // Captured per update
  logic [6:0] tens_pat, ones_pat;
  logic       tens_blank;
  logic [2:0] grp;     // effective group size, 1..7
  logic [2:0] offset;  // first segment of current group, 0..6

  // Decode of the incoming count: divide by 10 via reciprocal 205/2048
  logic        over;
  logic [15:0] prod;
  logic [3:0]  tens_d, ones_d;
  logic [7:0]  ones_wide;

  always_comb begin
    over      = (count_value > MAX_SHOWN);
    prod      = 16'(count_value) * 16'd205;
    tens_d    = prod[14:11];
    ones_wide = count_value - {1'b0, tens_d, 3'b000} - {3'b000, tens_d, 1'b0};
    ones_d    = ones_wide[3:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tens_pat   <= over ? GLYPH_SMALL_O : digit_glyph(tens_d);
      ones_pat   <= over ? GLYPH_BIG_F : digit_glyph(ones_d);
      tens_blank <= !over && (tens_d == 4'd0);
      grp        <= (segments_per_group == 3'd0) ? 3'd1 : segments_per_group;
    end
  end

  // Group mask and end-of-digit detection
  logic [3:0]  next_off;
  logic [13:0] grp_bits;
  logic [6:0]  pattern, mask;
  logic [13:0] rest;
  logic        emit;

  always_comb begin
    next_off = {1'b0, offset} + {1'b0, grp};
    grp_bits = ((14'd1 << grp) - 14'd1) << offset;
    pattern  = cmd.pol ? (cmd.digit ? ones_pat : tens_pat) : ALL_SEGS;
    mask     = grp_bits[6:0] & pattern;
    rest     = {7'd0, ones_pat} >> next_off;
    emit     = cmd.run && (!cmd.pol || (mask != 7'd0));
  end

  assign status.group_last = (next_off >= 4'(NUM_SEGS));
  assign status.tens_blank = tens_blank;

  // Group offset counter
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      offset <= 3'd0;
    end else if (cmd.run) begin
      offset <= status.group_last ? 3'd0 : next_off[2:0];
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_valid <= 1'b0;
    end else begin
      pulse_valid <= emit;
    end
  end

  // Pulse bytes
  always_ff @(posedge clk) begin
    if (emit) begin
      digit_select <= cmd.digit;
      polarity     <= cmd.pol;
      segment_mask <= mask;
      pulse_ms     <= cmd.pol ? set_pulse_ms : clear_pulse_ms;
      last_pulse   <= cmd.digit && cmd.pol && (rest == 14'd0);
      if (!cmd.digit) begin
        dir_port0   <= ~(COM_BIT | {1'b0, mask});
        level_port0 <= cmd.pol ? {1'b0, mask} : (COM_BIT | ~{1'b0, mask});
        dir_port1   <= 8'hFF;
        level_port1 <= 8'h00;
      end else begin
        dir_port0   <= ~COM_BIT;
        level_port0 <= cmd.pol ? ~COM_BIT : COM_BIT;
        dir_port1   <= ~{1'b0, mask};
        level_port1 <= cmd.pol ? {1'b0, mask} : ~{1'b0, mask};
      end
    end
  end

endmodule

// File: rtl/segment_display_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// segment_display_pulse_sequencer
// Turns a count byte into the drive pulse sequence of a two-digit bistable
// seven-segment display behind a dual-port I/O expander.
// ----------------------------------------------------------------------------
// Start is taken in idle with a load of the count; the first pulse comes from
// the clear tens phase and is registered. Each phase works one segment group
// per cycle, and busy covers three or four phases; set groups with no lit
// segment take their turn but strobe nothing. One update at a time: start is
// taken only while busy is low.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset (rst, synchronous): idle, no strobe, registers back to 2 / 75 / 250.
module segment_display_pulse_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  count_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        pulse_valid,
  output logic        digit_select,
  output logic        polarity,
  output logic [6:0]  segment_mask,
  output logic [7:0]  dir_port0,
  output logic [7:0]  level_port0,
  output logic [7:0]  dir_port1,
  output logic [7:0]  level_port1,
  output logic [15:0] pulse_ms,
  output logic        last_pulse
);
  import sdps_pkg::*;

  logic [2:0]   segments_per_group;
  logic [15:0]  clear_pulse_ms;
  logic [15:0]  set_pulse_ms;
  sdps_cmd_t    cmd;
  sdps_status_t status;

  assign cfg_ready = !busy;

  // Configuration registers; unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      segments_per_group <= SEGS_PER_GROUP_RST;
      clear_pulse_ms     <= CLEAR_MS_RST;
      set_pulse_ms       <= SET_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEGS_PER_GROUP: segments_per_group <= cfg_data[2:0];
        CFG_CLEAR_MS:       clear_pulse_ms     <= cfg_data;
        CFG_SET_MS:         set_pulse_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  sdps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sdps_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .count_value        (count_value),
    .segments_per_group (segments_per_group),
    .clear_pulse_ms     (clear_pulse_ms),
    .set_pulse_ms       (set_pulse_ms),
    .status             (status),
    .pulse_valid        (pulse_valid),
    .digit_select       (digit_select),
    .polarity           (polarity),
    .segment_mask       (segment_mask),
    .dir_port0          (dir_port0),
    .level_port0        (level_port0),
    .dir_port1          (dir_port1),
    .level_port1        (level_port1),
    .pulse_ms           (pulse_ms),
    .last_pulse         (last_pulse)
  );

endmodule
